>>> rtl/vm_instruction_execute_unit_macros.svh
// ---------------------------------------------------------------------------
// vm instruction execute unit assertion macros
// shared concurrent assertion forms used by the rtl
// ---------------------------------------------------------------------------
`ifndef VM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define VM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VIE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vie assertion failed");

// next-cycle implication, disabled in reset
`define VIE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vie assertion failed");

`endif

>>> rtl/vie_pkg.sv
// ---------------------------------------------------------------------------
// vie_pkg
// shared constants, opcodes and types of the vm instruction execute unit
// ---------------------------------------------------------------------------
`default_nettype none

package vie_pkg;

    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam int WORD_W    = 32;
    localparam int ADDR_IN_W = 10;
    localparam int IMM_W     = 16;
    localparam int IDX_W     = 3;
    localparam int OP_W      = 5;

    localparam int OP_LSB    = 27;
    localparam int IDX1_LSB  = 24;
    localparam int IDX2_LSB  = 21;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 56;

    typedef enum logic [OP_W-1:0] {
        OP_JMP   = 5'd0,
        OP_JMPI  = 5'd1,
        OP_JMPIG = 5'd2,
        OP_JMPIL = 5'd3,
        OP_JMPIE = 5'd4,
        OP_ADDI  = 5'd8,
        OP_SUBI  = 5'd9,
        OP_ANDI  = 5'd10,
        OP_ORI   = 5'd11,
        OP_LDI   = 5'd12,
        OP_LDD   = 5'd13,
        OP_STD   = 5'd14,
        OP_ADD   = 5'd16,
        OP_SUB   = 5'd17,
        OP_AND   = 5'd18,
        OP_OR    = 5'd19,
        OP_LDX   = 5'd20,
        OP_STX   = 5'd21,
        OP_NOT   = 5'd24,
        OP_SHL   = 5'd25,
        OP_SHR   = 5'd26,
        OP_SWAP  = 5'd27,
        OP_MULT  = 5'd28,
        OP_STOP  = 5'd31
    } opcode_t;

    typedef struct packed {
        logic [IDX_W-1:0]  first_index;
        logic [IMM_W-1:0]  second_field;
        logic [WORD_W-1:0] result_value;
        logic              write_back;
        logic              branch_taken;
        logic              halt;
        logic              invalid;
        logic              is_store;
        logic              addr_ok;
    } exec_t;

    typedef struct packed {
        logic              busy;
        logic [MEM_AW-1:0] addr;
    } clr_status_t;

    function automatic logic [MEM_AW-1:0] mem_index(input logic [ADDR_IN_W-1:0] addr);
        logic [31:0] wide;
        wide = 32'(addr);
        return wide[MEM_AW-1:0];
    endfunction

    function automatic logic addr_in_range(input logic [ADDR_IN_W-1:0] addr);
        return 32'(addr) < 32'(MEM_WORDS);
    endfunction

endpackage

`default_nettype wire

>>> rtl/vm_instruction_execute_unit.sv
// ---------------------------------------------------------------------------
// vm_instruction_execute_unit
// execute stage of a small 32-bit vm with a 1024-word data memory
// ---------------------------------------------------------------------------
// usage
//   s_ channel carries one instruction request per beat: instruction word,
//   both register values and the data memory word address
//   m_ channel returns one result per request: register indexes, result
//   value and the write back, branch taken, halt and invalid flags
//   a request passes the input register, whose cycle covers decode, alu and
//   the data memory read, and then the output register
//   throughput is one request per cycle while m_tready is high; the data
//   memory read is issued at accept and a store is written as it leaves
//   the input register, with a bypass for a load directly behind a store
//   to the same word
//   after reset the data memory is swept to zero, one word per cycle, over
//   all 1024 words; s_tready stays low for that time
//   when m_tready is low the output register holds its result, the input
//   register can still fill, and s_tready drops once both are full
// ---------------------------------------------------------------------------
`default_nettype none

`include "vm_instruction_execute_unit_macros.svh"

module vm_instruction_execute_unit
    import vie_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // instruction[31:0], reg_a[63:32], reg_b[95:64], mem_address[105:96], zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // first_index[2:0], second_field[18:3], result_value[50:19], write_back[51],
    // branch_taken[52], halt[53], invalid[54], zero pad
    output logic      [M_TDATA_W-1:0] m_tdata
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [WORD_W-1:0]    s1_inst_reg;
    logic [WORD_W-1:0]    s1_a_reg;
    logic [WORD_W-1:0]    s1_b_reg;
    logic [ADDR_IN_W-1:0] s1_addr_reg;
    logic                 s1_fwd_reg;
    logic                 s1_fwd_next;
    logic [WORD_W-1:0]    s1_fwd_data_reg;

    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [WORD_W-1:0]    in_inst;
    logic [WORD_W-1:0]    in_a;
    logic [WORD_W-1:0]    in_b;
    logic [ADDR_IN_W-1:0] in_addr;

    clr_status_t          clr;
    exec_t                ex;
    logic                 advance;
    logic                 s_accept;
    logic                 store_we;
    logic [MEM_AW-1:0]    rd_index;
    logic [MEM_AW-1:0]    st_index;
    logic                 ram_we;
    logic [MEM_AW-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic [WORD_W-1:0]    load_data;

    assign in_inst = s_tdata[WORD_W-1:0];
    assign in_a    = s_tdata[2*WORD_W-1:WORD_W];
    assign in_b    = s_tdata[3*WORD_W-1:2*WORD_W];
    assign in_addr = s_tdata[3*WORD_W +: ADDR_IN_W];

    vie_clear u_clear (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (clr)
    );

    assign load_data = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;

    vie_alu u_alu (
        .instruction (s1_inst_reg),
        .reg_a       (s1_a_reg),
        .reg_b       (s1_b_reg),
        .mem_address (s1_addr_reg),
        .load_data   (load_data),
        .res         (ex)
    );

    assign advance  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr.busy && (!s1_valid_reg || advance);
    assign s_accept = s_tvalid && s_tready;

    assign store_we  = advance && ex.is_store && ex.addr_ok;
    assign rd_index  = mem_index(in_addr);
    assign st_index  = mem_index(s1_addr_reg);

    assign ram_we    = clr.busy || store_we;
    assign ram_waddr = clr.busy ? clr.addr : st_index;
    assign ram_wdata = clr.busy ? '0 : s1_a_reg;

    vie_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (rd_index),
        .rdata (ram_rdata)
    );

    // store leaving stage one lands in the same edge the load is read
    assign s1_fwd_next = store_we && (st_index == rd_index);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_inst_reg     <= in_inst;
            s1_a_reg        <= in_a;
            s1_b_reg        <= in_b;
            s1_addr_reg     <= in_addr;
            s1_fwd_reg      <= s1_fwd_next;
            s1_fwd_data_reg <= s1_a_reg;
        end
        if (advance) begin
            m_data_reg <= {1'b0, ex.invalid, ex.halt, ex.branch_taken, ex.write_back,
                           ex.result_value, ex.second_field, ex.first_index};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `VIE_ASSERT_NOW(a_no_accept_in_clear, aclk, aresetn, clr.busy, !s_tready)
    `VIE_ASSERT_NOW(a_ram_write_source, aclk, aresetn, ram_we,
                    clr.busy || (advance && ex.is_store))
    `VIE_ASSERT_NEXT(a_fwd_captured, aclk, aresetn, s_accept && s1_fwd_next,
                     s1_valid_reg && s1_fwd_reg)
    `VIE_ASSERT_NOW(a_flags_exclusive, aclk, aresetn, m_valid_reg,
                    $onehot0(m_data_reg[54:51]))
    `VIE_ASSERT_NOW(a_result_zero_no_wb, aclk, aresetn, m_valid_reg && !m_data_reg[51],
                    m_data_reg[50:19] == '0)

endmodule

`default_nettype wire

>>> rtl/vie_ram.sv
// ---------------------------------------------------------------------------
// vie_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none

module vie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/vie_clear.sv
// ---------------------------------------------------------------------------
// vie_clear
// post-reset sweep that writes zero to every data memory word
// ---------------------------------------------------------------------------
`default_nettype none

module vie_clear
    import vie_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    output clr_status_t status
);

    logic              busy_reg;
    logic              busy_next;
    logic [MEM_AW-1:0] addr_reg;
    logic [MEM_AW-1:0] addr_next;

    always_comb begin
        busy_next = busy_reg;
        addr_next = addr_reg;
        if (busy_reg) begin
            addr_next = addr_reg + 1'b1;
            if (addr_reg == MEM_AW'(MEM_WORDS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            addr_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.addr = addr_reg;

endmodule

`default_nettype wire

>>> rtl/vie_alu.sv
// ---------------------------------------------------------------------------
// vie_alu
// instruction decode, alu, branch condition and flag generation
// ---------------------------------------------------------------------------
`default_nettype none

module vie_alu
    import vie_pkg::*;
(
    input  wire logic [WORD_W-1:0]    instruction,
    input  wire logic [WORD_W-1:0]    reg_a,
    input  wire logic [WORD_W-1:0]    reg_b,
    input  wire logic [ADDR_IN_W-1:0] mem_address,
    input  wire logic [WORD_W-1:0]    load_data,
    output exec_t                     res
);

    logic [OP_W-1:0]   op;
    logic              use_imm;
    logic [WORD_W-1:0] operand2;
    logic [WORD_W-1:0] product;

    assign op       = instruction[OP_LSB +: OP_W];
    assign use_imm  = (op == OP_JMP) || ((op >= OP_ADDI) && (op <= OP_STD));
    assign operand2 = use_imm ? WORD_W'(instruction[IMM_W-1:0]) : reg_b;
    assign product  = reg_a * operand2;

    always_comb begin
        res              = '0;
        res.first_index  = instruction[IDX1_LSB +: IDX_W];
        res.second_field = use_imm ? instruction[IMM_W-1:0]
                                   : IMM_W'(instruction[IDX2_LSB +: IDX_W]);
        res.addr_ok      = addr_in_range(mem_address);
        case (opcode_t'(op))
            OP_JMP, OP_JMPI: begin
                res.branch_taken = 1'b1;
            end
            OP_JMPIG: begin
                res.branch_taken = !reg_b[WORD_W-1] && (reg_b != '0);
            end
            OP_JMPIL: begin
                res.branch_taken = reg_b[WORD_W-1];
            end
            OP_JMPIE: begin
                res.branch_taken = (reg_b == '0);
            end
            OP_ADDI, OP_ADD: begin
                res.result_value = reg_a + operand2;
                res.write_back   = 1'b1;
            end
            OP_SUBI, OP_SUB: begin
                res.result_value = reg_a - operand2;
                res.write_back   = 1'b1;
            end
            OP_ANDI, OP_AND: begin
                res.result_value = reg_a & operand2;
                res.write_back   = 1'b1;
            end
            OP_ORI, OP_OR: begin
                res.result_value = reg_a | operand2;
                res.write_back   = 1'b1;
            end
            OP_LDI: begin
                res.result_value = operand2;
                res.write_back   = 1'b1;
            end
            OP_LDD, OP_LDX: begin
                res.result_value = res.addr_ok ? load_data : '0;
                res.write_back   = 1'b1;
            end
            OP_STD, OP_STX: begin
                res.is_store = 1'b1;
            end
            OP_NOT: begin
                res.result_value = ~reg_a;
                res.write_back   = 1'b1;
            end
            OP_SHL: begin
                res.result_value = {reg_a[WORD_W-2:0], 1'b0};
                res.write_back   = 1'b1;
            end
            OP_SHR: begin
                res.result_value = {reg_a[WORD_W-1], reg_a[WORD_W-1:1]};
                res.write_back   = 1'b1;
            end
            OP_SWAP: begin
                res.write_back = 1'b0;
            end
            OP_MULT: begin
                res.result_value = product;
                res.write_back   = 1'b1;
            end
            OP_STOP: begin
                res.halt = 1'b1;
            end
            default: begin
                res.invalid = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire
